// ----- rtl/vsar_pkg.sv -----
package vsar_pkg;

    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned FETCH_W = 14;
    localparam int unsigned TDATA_W = 72;

    localparam logic [ADDR_W-1:0] HORIZ_BITS = 15'h041F;

    typedef enum logic [3:0] {
        FUNC_CTRL_WR   = 4'd0,
        FUNC_MASK_WR   = 4'd1,
        FUNC_SCROLL_WR = 4'd2,
        FUNC_ADDR_WR   = 4'd3,
        FUNC_STATUS_RD = 4'd4,
        FUNC_DATA_ACC  = 4'd5,
        FUNC_INC_X     = 4'd6,
        FUNC_INC_Y     = 4'd7,
        FUNC_COPY_X    = 4'd8,
        FUNC_COPY_Y    = 4'd9
    } func_t;

    typedef struct packed {
        logic [ADDR_W-1:0] cur_addr;
        logic [ADDR_W-1:0] tmp_addr;
        logic [2:0]        fine_scroll_x;
        logic              second_write;
        logic              step_by_row;
        logic              rendering_on;
    } vsar_state_t;

    typedef struct packed {
        logic [FETCH_W-1:0] nt_fetch_addr;
        logic [FETCH_W-1:0] attr_fetch_addr;
        logic [2:0]         attr_shift;
    } vsar_fetch_t;

endpackage

// ----- rtl/vsar_step.sv -----
module vsar_step (
    input  logic [3:0]           func,
    input  logic [7:0]           data,
    input  vsar_pkg::vsar_state_t state_cur,
    output vsar_pkg::vsar_state_t state_next
);
    import vsar_pkg::*;

    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] tmp;
    logic [ADDR_W-1:0] x_step;
    logic [ADDR_W-1:0] y_step;
    logic [4:0]        row;
    logic              nt_v;
    logic [ADDR_W-1:0] step_amt;

    assign cur = state_cur.cur_addr;
    assign tmp = state_cur.tmp_addr;

    // coarse x step with horizontal nametable flip
    always_comb begin
        if (cur[4:0] == 5'd31) begin
            x_step = {cur[14:11], ~cur[10], cur[9:5], 5'd0};
        end else begin
            x_step = {cur[14:5], cur[4:0] + 5'd1};
        end
    end

    // fine y / coarse y step with row 29 wrap
    always_comb begin
        row  = cur[9:5];
        nt_v = cur[11];
        if (cur[14:12] != 3'd7) begin
            y_step = {cur[14:12] + 3'd1, cur[11:0]};
        end else begin
            if (row == 5'd29) begin
                row  = 5'd0;
                nt_v = ~cur[11];
            end else if (row == 5'd31) begin
                row = 5'd0;
            end else begin
                row = row + 5'd1;
            end
            y_step = {3'd0, nt_v, cur[10], row, cur[4:0]};
        end
    end

    assign step_amt = state_cur.step_by_row ? ADDR_W'(32) : ADDR_W'(1);

    always_comb begin
        state_next = state_cur;
        unique case (func)
            FUNC_CTRL_WR: begin
                state_next.tmp_addr[11:10] = data[1:0];
                state_next.step_by_row     = data[2];
            end
            FUNC_MASK_WR: begin
                state_next.rendering_on = data[3] | data[4];
            end
            FUNC_SCROLL_WR: begin
                if (!state_cur.second_write) begin
                    state_next.fine_scroll_x = data[2:0];
                    state_next.tmp_addr[4:0] = data[7:3];
                end else begin
                    state_next.tmp_addr[14:12] = data[2:0];
                    state_next.tmp_addr[9:5]   = data[7:3];
                end
                state_next.second_write = ~state_cur.second_write;
            end
            FUNC_ADDR_WR: begin
                if (!state_cur.second_write) begin
                    state_next.tmp_addr = {1'b0, data[5:0], tmp[7:0]};
                end else begin
                    state_next.tmp_addr = {tmp[14:8], data};
                    state_next.cur_addr = {tmp[14:8], data};
                end
                state_next.second_write = ~state_cur.second_write;
            end
            FUNC_STATUS_RD: begin
                state_next.second_write = 1'b0;
            end
            FUNC_DATA_ACC: begin
                state_next.cur_addr = cur + step_amt;
            end
            FUNC_INC_X: begin
                if (state_cur.rendering_on) begin
                    state_next.cur_addr = x_step;
                end
            end
            FUNC_INC_Y: begin
                if (state_cur.rendering_on) begin
                    state_next.cur_addr = y_step;
                end
            end
            FUNC_COPY_X: begin
                if (state_cur.rendering_on) begin
                    state_next.cur_addr = (cur & ~HORIZ_BITS) | (tmp & HORIZ_BITS);
                end
            end
            FUNC_COPY_Y: begin
                if (state_cur.rendering_on) begin
                    state_next.cur_addr = (cur & HORIZ_BITS) | (tmp & ~HORIZ_BITS);
                end
            end
            default: begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

// ----- rtl/vsar_fetch.sv -----
module vsar_fetch (
    input  logic [vsar_pkg::ADDR_W-1:0] vram_addr,
    output vsar_pkg::vsar_fetch_t       fetch
);
    import vsar_pkg::*;

    assign fetch.nt_fetch_addr   = {2'b10, vram_addr[11:0]};
    assign fetch.attr_fetch_addr = {2'b10, vram_addr[11:10], 4'b1111,
                                    vram_addr[9:7], vram_addr[4:2]};
    assign fetch.attr_shift      = {vram_addr[6], vram_addr[1], 1'b0};

endmodule

// ----- rtl/video_scroll_address_registers_core.sv -----
// an accepted item is held in the input register, then its result is registered
// throughput: one item per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken
// reset: synchronous active-low aresetn clears all scroll and address registers,
// the increment mode, the rendering enable and both valid flags
module video_scroll_address_registers_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // data
    input  logic [3:0]                    s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vram_addr, temp_addr, fine_x, write_toggle, nt_fetch_addr,
    // attr_fetch_addr, attr_shift, zero fill
    output logic [vsar_pkg::TDATA_W-1:0]  m_tdata
);
    import vsar_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [3:0]  in_func_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    vsar_state_t state_reg, state_next;
    vsar_fetch_t fetch;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    vsar_step u_step (
        .func       (in_func_reg),
        .data       (in_data_reg),
        .state_cur  (state_reg),
        .state_next (state_next)
    );

    vsar_fetch u_fetch (
        .vram_addr (state_next.cur_addr),
        .fetch     (fetch)
    );

    always_comb begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        out_data_next = {7'd0, fetch.attr_shift, fetch.attr_fetch_addr,
                         fetch.nt_fetch_addr, state_next.second_write,
                         state_next.fine_scroll_x, state_next.tmp_addr,
                         state_next.cur_addr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_func_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
